// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold at the next edge after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/tes_pkg.sv
// ---------------------------------------------------------------------------
// tes_pkg
// types, corner loop and edge table for tetrahedron edge selection
// ---------------------------------------------------------------------------
package tes_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [2:0] LAST_TET = 3'd5;

  typedef struct packed {
    logic [7:0] corner_inside_mask;
    logic [2:0] tet_index;
  } in_item_t;

  typedef struct packed {
    logic       triangle_number;
    logic [1:0] vertex_number;
    logic [2:0] inside_corner;
    logic [2:0] outside_corner;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] corner2;
    logic [2:0] corner3;
    logic [3:0] pattern;
    logic       two_tri;
  } job_t;

  function automatic logic [2:0] corner_ring(input logic [2:0] idx);
    logic [2:0] c;
    case (idx)
      3'd0:    c = 3'd6;
      3'd1:    c = 3'd4;
      3'd2:    c = 3'd5;
      3'd3:    c = 3'd1;
      3'd4:    c = 3'd3;
      3'd5:    c = 3'd2;
      3'd6:    c = 3'd6;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic two_tris(input logic [3:0] p);
    return (p == 4'd3) || (p == 4'd5) || (p == 4'd6) ||
           (p == 4'd9) || (p == 4'd10) || (p == 4'd12);
  endfunction

  // nibble k of a row: inside vertex in [3:2], outside vertex in [1:0]
  function automatic logic [3:0] edge_code(input logic [3:0] p, input logic [2:0] k);
    logic [23:0] row;
    case (p)
      4'd1:    row = 24'h000312;
      4'd2:    row = 24'h000764;
      4'd3:    row = 24'h623376;
      4'd4:    row = 24'h0009B8;
      4'd5:    row = 24'h3199B3;
      4'd6:    row = 24'h47BB84;
      4'd7:    row = 24'h00037B;
      4'd8:    row = 24'h000EDC;
      4'd9:    row = 24'hED112E;
      4'd10:   row = 24'h64CCE6;
      4'd11:   row = 24'h0002E6;
      4'd12:   row = 24'hC899DC;
      4'd13:   row = 24'h00019D;
      4'd14:   row = 24'h00084C;
      default: row = 24'h000000;
    endcase
    return row[{k, 2'b00} +: 4];
  endfunction

endpackage

// File: src/tes_front.sv
// ---------------------------------------------------------------------------
// tes_front
// accepts input items, forms the inside pattern and drops empty cases
// ---------------------------------------------------------------------------
module tes_front import tes_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_item,
  output logic     q_push,
  input  logic     q_full,
  output job_t     q_job
);

  logic     vld_r, vld_nxt;
  job_t     job_r, job_nxt;
  logic     accept, useful;
  logic [2:0] c2, c3;

  assign in_full = vld_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = vld_r && !q_full;
  assign q_job   = job_r;

  always_comb begin
    c2 = corner_ring(in_item.tet_index);
    c3 = corner_ring(in_item.tet_index + 3'd1);
    job_nxt.corner2 = c2;
    job_nxt.corner3 = c3;
    job_nxt.pattern = {in_item.corner_inside_mask[c3], in_item.corner_inside_mask[c2],
                       in_item.corner_inside_mask[7], in_item.corner_inside_mask[0]};
    job_nxt.two_tri = two_tris(job_nxt.pattern);
    // patterns all-outside and all-inside give no triangles
    useful = (in_item.tet_index <= LAST_TET) &&
             (job_nxt.pattern != 4'h0) && (job_nxt.pattern != 4'hF);
    vld_nxt = accept ? useful : (vld_r && q_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

endmodule

// File: src/tes_queue.sv
// ---------------------------------------------------------------------------
// tes_queue
// short job queue between front and back
// ---------------------------------------------------------------------------
module tes_queue import tes_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head_job,
  output logic empty
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: src/tes_back.sv
// ---------------------------------------------------------------------------
// tes_back
// steps through the triangle vertices of one job, one result per cycle while out_pop takes each result
// ---------------------------------------------------------------------------
module tes_back import tes_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  job_t      job_r;
  logic      job_v_r, job_v_nxt;
  logic      tri_r, tri_nxt;
  logic [1:0] vtx_r, vtx_nxt;
  logic      out_v_r;
  out_item_t out_r, res;
  logic      take, adv, fin, load;
  logic [2:0] k;
  logic [3:0] code;

  function automatic logic [2:0] tet_corner(input job_t j, input logic [1:0] v);
    logic [2:0] c;
    case (v)
      2'd0:    c = 3'd0;
      2'd1:    c = 3'd7;
      2'd2:    c = j.corner2;
      2'd3:    c = j.corner3;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  assign take      = out_pop && out_v_r;
  assign adv       = job_v_r && (!out_v_r || take);
  assign out_empty = !out_v_r;
  assign out_item  = out_r;

  always_comb begin
    k    = tri_r ? ({1'b0, vtx_r} + 3'd3) : {1'b0, vtx_r};
    code = edge_code(job_r.pattern, k);
    res.triangle_number = tri_r;
    res.vertex_number   = vtx_r;
    res.inside_corner   = tet_corner(job_r, code[3:2]);
    res.outside_corner  = tet_corner(job_r, code[1:0]);
    res.last            = (vtx_r == 2'd2) && (tri_r == job_r.two_tri);
    fin  = adv && res.last;
    load = (!job_v_r || fin) && !q_empty;
    q_pop = load;
    job_v_nxt = load ? 1'b1 : (fin ? 1'b0 : job_v_r);
    tri_nxt = tri_r;
    vtx_nxt = vtx_r;
    if (load) begin
      tri_nxt = 1'b0;
      vtx_nxt = 2'd0;
    end else if (adv) begin
      if (vtx_r == 2'd2) begin
        tri_nxt = 1'b1;
        vtx_nxt = 2'd0;
      end else begin
        vtx_nxt = vtx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      out_v_r <= 1'b0;
      tri_r   <= 1'b0;
      vtx_r   <= 2'd0;
    end else begin
      job_v_r <= job_v_nxt;
      tri_r   <= tri_nxt;
      vtx_r   <= vtx_nxt;
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (take) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= q_job;
    end
    if (adv) begin
      out_r <= res;
    end
  end

endmodule

// File: src/tetra_edge_select_top.sv
// ---------------------------------------------------------------------------
// tetra_edge_select_top
// marching-tetrahedra edge selection for one tetrahedron of a voxel
// ---------------------------------------------------------------------------
// input channel: in_item carries the corner inside mask and the tetrahedron
// number; a request is taken at a clock edge with in_push high, in_full low.
// result channel: while out_empty is low, out_item holds the oldest result;
// it is taken at an edge with out_pop high.
// each request yields 0, 3 or 6 results, one per crossed edge, the final one
// flagged by last; tetrahedron numbers 6 and 7 and patterns with all corners
// inside or all outside yield none.
// a request passes the front register, the job queue and the back-end job
// register before its first result is registered. throughput: one result
// per cycle while out_pop takes each result, set by the single vertex
// stepper in the back end; the front end takes a request every cycle while
// the job queue has room. when out_pop stays low, the output register holds,
// the stepper waits, the queue fills and in_full rises; nothing is lost.
// reset clears the front register, queue pointers, stepper and output valid.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tetra_edge_select_top import tes_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic f_push, q_full, q_pop, q_empty;
  job_t f_job, q_head;

  tes_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_push  (f_push),
    .q_full  (q_full),
    .q_job   (f_job)
  );

  tes_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .push_job (f_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (q_head),
    .empty    (q_empty)
  );

  tes_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  `ASSERT_ALWAYS(a_vtx_range, out_empty || (out_item.vertex_number != 2'd3), "vertex number out of range")
  `ASSERT_ALWAYS(a_last_vtx, out_empty || !out_item.last || (out_item.vertex_number == 2'd2), "last not on a third vertex")
  `ASSERT_ALWAYS(a_edge_ends, out_empty || (out_item.inside_corner != out_item.outside_corner), "edge ends coincide")
  `ASSERT_NEXT(a_full_holds, in_full && !out_pop, in_full || !out_empty, "queue drained without a pop")

endmodule
